// ===== rtl/urxd_pkg.sv =====
// Shared types and constants for the USB receive deframer.
package urxd_pkg;

	// Parser phase within one frame record.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SKIP   = 2'd1,
		PH_FRAME  = 2'd2,
		PH_PAD    = 2'd3
	} phase_t;

	// Width of the frame length field.
	localparam int LEN_W = 15;

	// One result word handed to the output stage.
	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic [LEN_W-1:0] length;
	} result_t;

endpackage

// ===== rtl/urxd_parser.sv =====
// Record parser: header assembly, descriptor skip, frame pass-through and padding drop.
module urxd_parser #(
	parameter int LEN_MASK_BITS   = 15,
	parameter int ALIGN_BYTES     = 8,
	parameter int DESC_SKIP_BYTES = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output logic                emit,
	output urxd_pkg::result_t   result
);

	localparam int LMB = (LEN_MASK_BITS > urxd_pkg::LEN_W) ? urxd_pkg::LEN_W : LEN_MASK_BITS;
	localparam logic [15:0] MASK16 = (16'd1 << LMB) - 16'd1;
	localparam logic [urxd_pkg::LEN_W-1:0] LEN_MASK = MASK16[urxd_pkg::LEN_W-1:0];
	localparam logic [urxd_pkg::LEN_W-1:0] SKIP_CNT = urxd_pkg::LEN_W'(DESC_SKIP_BYTES);
	localparam int PW = $clog2(ALIGN_BYTES + 1);
	localparam logic [PW-1:0] ALIGN_LAST = PW'(ALIGN_BYTES - 1);

	urxd_pkg::phase_t phase_q, phase_d;
	logic [1:0]                  hdr_cnt_q, hdr_cnt_d;
	logic [urxd_pkg::LEN_W-1:0]  len_q, len_d;
	logic [urxd_pkg::LEN_W-1:0]  cnt_q, cnt_d;
	logic [PW-1:0]               pos_q, pos_d;
	logic [urxd_pkg::LEN_W-1:0]  len_asm;
	logic [PW-1:0]               pos_inc;

	// Length assembly from the little-endian header bytes, under the mask.
	always_comb begin
		case (hdr_cnt_q)
			2'd0:    len_asm = {7'd0, rx_byte} & LEN_MASK;
			2'd1:    len_asm = (len_q | {rx_byte[6:0], 8'd0}) & LEN_MASK;
			default: len_asm = len_q & LEN_MASK;
		endcase
	end

	// Alignment position, wrapping at the alignment.
	assign pos_inc = (pos_q == ALIGN_LAST) ? '0 : pos_q + PW'(1);

	// Next-state logic.
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		case (phase_q)
			urxd_pkg::PH_HEADER: begin
				len_d     = len_asm;
				hdr_cnt_d = hdr_cnt_q + 2'd1;
				if (hdr_cnt_q == 2'd3) begin
					if (SKIP_CNT != '0) begin
						phase_d = urxd_pkg::PH_SKIP;
						cnt_d   = SKIP_CNT;
					end else if (len_asm != '0) begin
						phase_d = urxd_pkg::PH_FRAME;
						cnt_d   = len_asm;
						pos_d   = '0;
					end
				end
			end
			urxd_pkg::PH_SKIP: begin
				cnt_d = cnt_q - urxd_pkg::LEN_W'(1);
				if (cnt_q == urxd_pkg::LEN_W'(1)) begin
					if (len_q != '0) begin
						phase_d = urxd_pkg::PH_FRAME;
						cnt_d   = len_q;
						pos_d   = '0;
					end else begin
						phase_d = urxd_pkg::PH_HEADER;
					end
				end
			end
			urxd_pkg::PH_FRAME: begin
				cnt_d = cnt_q - urxd_pkg::LEN_W'(1);
				pos_d = pos_inc;
				if (cnt_q == urxd_pkg::LEN_W'(1)) begin
					phase_d = (pos_inc == '0) ? urxd_pkg::PH_HEADER : urxd_pkg::PH_PAD;
				end
			end
			urxd_pkg::PH_PAD: begin
				pos_d = pos_inc;
				if (pos_inc == '0) begin
					phase_d = urxd_pkg::PH_HEADER;
				end
			end
			default: phase_d = urxd_pkg::PH_HEADER;
		endcase
	end

	// Output logic: frame bytes pass through with the last mark.
	always_comb begin
		emit          = step && (phase_q == urxd_pkg::PH_FRAME);
		result.data   = rx_byte;
		result.last   = (cnt_q == urxd_pkg::LEN_W'(1));
		result.length = len_q;
	end

	// State registers advance on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= urxd_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			pos_q     <= pos_d;
		end
	end

endmodule

// ===== rtl/usb_rx_aggregate_deframer_unit.sv =====
// Top level of the USB bulk-IN receive deframer with its output and skid registers.
// Accepted frame bytes go to the output register, or to the skid register on a stall.
// Throughput: one input word per cycle while the skid is empty; counters update in one pass.
// A stalled output is absorbed by a one-word skid register, so input stalls only when both fill.
// Reset (arst_n low, asynchronous) returns the parser to the header phase and empties both
// output registers.
module usb_rx_aggregate_deframer_unit #(
	parameter int LEN_MASK_BITS   = 15,
	parameter int ALIGN_BYTES     = 8,
	parameter int DESC_SKIP_BYTES = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        frame_last,
	output logic [14:0] frame_length
);

	logic              step;
	logic              emit;
	urxd_pkg::result_t res;
	urxd_pkg::result_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;

	assign in_ready = !skid_valid_q;
	assign step     = in_valid && in_ready;

	urxd_parser #(
		.LEN_MASK_BITS  (LEN_MASK_BITS),
		.ALIGN_BYTES    (ALIGN_BYTES),
		.DESC_SKIP_BYTES(DESC_SKIP_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_byte(rx_byte),
		.emit   (emit),
		.result (res)
	);

	// Output register with skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || emit;
			skid_valid_q <= 1'b0;
		end else if (emit) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (emit) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_byte   = out_q.data;
	assign frame_last   = out_q.last;
	assign frame_length = out_q.length;

endmodule
